// ----- rtl/core/lan_pkg.sv -----
// Shared types and constants for the level autorange normalizer.
// No dependencies; imported by lan_window, lan_div and the top level.
`timescale 1ns / 1ps

package lan_pkg;

    localparam int LEVEL_W = 16;
    localparam int TIME_W  = 32;
    localparam int PCT_W   = 15;
    localparam int X_W     = 18;
    localparam int X25_W   = 23;
    localparam int NUM_W   = 35;
    localparam int DEN_W   = 19;
    localparam int REM_W   = 20;

    localparam logic [PCT_W-1:0]   PCT_FULL  = 15'd25600;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_REACTIVE = 2'd0,
        MODE_STABLE   = 2'd1,
        MODE_CUSTOM   = 2'd2,
        MODE_UNUSED   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        CFG_MODE       = 3'd0,
        CFG_WINDOW_MS  = 3'd1,
        CFG_FORCED_MIN = 3'd2,
        CFG_FORCED_MAX = 3'd3,
        CFG_MIN_SPAN   = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] hi;
    } t_win_res;

    typedef struct packed {
        logic             done;
        logic [PCT_W-1:0] quot;
    } t_div_res;

endpackage

// ----- rtl/core/lan_window.sv -----
// Time window ring: ages out old entries, appends the new one, then walks
// the ring one entry per cycle for min and max. Depends on lan_pkg.
`timescale 1ns / 1ps

module lan_window
    import lan_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  logic               i_start,
    input  logic [LEVEL_W-1:0] i_level,
    input  logic [TIME_W-1:0]  i_time,
    input  logic [15:0]        i_window_ms,
    output t_win_res           o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    typedef enum logic [6:0] {
        W_IDLE    = 7'b0000001,
        W_AGE_RD  = 7'b0000010,
        W_AGE_CHK = 7'b0000100,
        W_FULL    = 7'b0001000,
        W_WR      = 7'b0010000,
        W_WALK    = 7'b0100000,
        W_DONE    = 7'b1000000
    } t_wstate;

    t_wstate            r_state;
    logic [AW-1:0]      r_head;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_ptr;
    logic [CW-1:0]      r_k;
    logic               r_rd_vld;
    logic [LEVEL_W-1:0] r_lo;
    logic [LEVEL_W-1:0] r_hi;
    logic [LEVEL_W-1:0] r_level;
    logic [TIME_W-1:0]  r_time;
    logic [TIME_W-1:0]  r_rd_time;
    logic [LEVEL_W-1:0] r_rd_level;

    logic [TIME_W-1:0]  r_mem_time  [DEPTH];
    logic [LEVEL_W-1:0] r_mem_level [DEPTH];

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [CW-1:0]      slot_sum;
    logic [AW-1:0]      slot;
    logic [TIME_W-1:0]  age;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        ring_inc = (a == LAST_IDX) ? '0 : a + 1'b1;
    endfunction

    always_comb begin
        slot_sum = {1'b0, r_head} + r_count;
        if (slot_sum >= FULL_CNT) begin
            slot_sum = slot_sum - FULL_CNT;
        end
        slot = slot_sum[AW-1:0];
        age  = r_time - r_rd_time;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_head;
        wr_en   = 1'b0;
        unique case (r_state)
            W_AGE_RD: begin
                rd_en = (r_count != '0);
            end
            W_WR: begin
                wr_en = 1'b1;
            end
            W_WALK: begin
                rd_en   = (r_k != r_count);
                rd_addr = r_ptr;
            end
            W_IDLE, W_AGE_CHK, W_FULL, W_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_time[slot]  <= r_time;
            r_mem_level[slot] <= r_level;
        end
        if (rd_en) begin
            r_rd_time  <= r_mem_time[rd_addr];
            r_rd_level <= r_mem_level[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= W_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_ptr    <= '0;
            r_k      <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            unique case (r_state)
                W_IDLE: begin
                    if (i_clear) begin
                        r_head  <= '0;
                        r_count <= '0;
                    end else if (i_start) begin
                        r_level <= i_level;
                        r_time  <= i_time;
                        r_state <= W_AGE_RD;
                    end
                end
                W_AGE_RD: begin
                    r_state <= (r_count == '0) ? W_FULL : W_AGE_CHK;
                end
                W_AGE_CHK: begin
                    if (age > {16'd0, i_window_ms}) begin
                        r_head  <= ring_inc(r_head);
                        r_count <= r_count - 1'b1;
                        r_state <= W_AGE_RD;
                    end else begin
                        r_state <= W_FULL;
                    end
                end
                W_FULL: begin
                    if (r_count == FULL_CNT) begin
                        r_head  <= ring_inc(r_head);
                        r_count <= FULL_CNT - 1'b1;
                    end
                    r_state <= W_WR;
                end
                W_WR: begin
                    r_count  <= r_count + 1'b1;
                    r_ptr    <= r_head;
                    r_k      <= '0;
                    r_rd_vld <= 1'b0;
                    r_lo     <= LEVEL_TOP;
                    r_hi     <= '0;
                    r_state  <= W_WALK;
                end
                W_WALK: begin
                    if (r_k != r_count) begin
                        r_ptr <= ring_inc(r_ptr);
                        r_k   <= r_k + 1'b1;
                    end
                    r_rd_vld <= (r_k != r_count);
                    if (r_rd_vld) begin
                        if (r_rd_level < r_lo) begin
                            r_lo <= r_rd_level;
                        end
                        if (r_rd_level > r_hi) begin
                            r_hi <= r_rd_level;
                        end
                    end
                    if (r_k == r_count && !r_rd_vld) begin
                        r_state <= W_DONE;
                    end
                end
                W_DONE: begin
                    r_state <= W_IDLE;
                end
                default: begin
                    r_state <= W_IDLE;
                end
            endcase
        end
    end

    assign o_res.done = (r_state == W_DONE);
    assign o_res.lo   = r_lo;
    assign o_res.hi   = r_hi;

endmodule

// ----- rtl/core/lan_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Quotient is known to fit PCT_W bits. Depends on lan_pkg.
`timescale 1ns / 1ps

module lan_div
    import lan_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output t_div_res         o_res
);

    logic [REM_W-1:0] r_rem;
    logic [PCT_W-1:0] r_sh;
    logic [PCT_W-1:0] r_quot;
    logic [DEN_W-1:0] r_den;
    logic [3:0]       r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [REM_W-1:0] trial;
    logic             take;

    always_comb begin
        trial = {r_rem[REM_W-2:0], r_sh[PCT_W-1]};
        take  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num[NUM_W-1:PCT_W];
                r_sh   <= i_num[PCT_W-1:0];
                r_den  <= i_den;
                r_quot <= '0;
                r_cnt  <= 4'(PCT_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= take ? trial - {1'b0, r_den} : trial;
                r_sh   <= {r_sh[PCT_W-2:0], 1'b0};
                r_quot <= {r_quot[PCT_W-2:0], take};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == 4'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

endmodule

// ----- rtl/core/level_autorange_normalizer.sv -----
// Level autorange normalizer: maps a timestamped level to Q7.8 percent.
// Reactive mode ages out old entries, appends the new one and walks the window for min
// and max before the bit-serial divide; stable and custom set up the divide from their own
// range. A narrow span skips the divide in every mode; unused mode goes straight to output.
// One transfer in flight; the next is accepted in idle, entered as the result registers.
// Synchronous active-low reset: FSM idle, output invalid, config defaults, window empty, range 65535..0.
`timescale 1ns / 1ps

module level_autorange_normalizer
    import lan_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // level_in[15:0], time_ms[47:16]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // level_percent[14:0], shown_min[30:15],
                                          // shown_max[46:31], zero pad[47]
    output logic [0:0]  o_m_axis_tuser,   // range_publish[0]
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_WIN   = 8'b00000010,
        S_ST    = 8'b00000100,
        S_CUS   = 8'b00001000,
        S_MUL   = 8'b00010000,
        S_DIVGO = 8'b00100000,
        S_DIV   = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state             r_state;
    t_mode              r_mode;
    logic [15:0]        r_window_ms;
    logic [15:0]        r_forced_min;
    logic [15:0]        r_forced_max;
    logic [15:0]        r_min_span;
    logic [LEVEL_W-1:0] r_ever_min;
    logic [LEVEL_W-1:0] r_ever_max;
    logic               r_changed;
    logic [LEVEL_W-1:0] r_v;
    logic [X_W-1:0]     r_x;
    logic [X_W-1:0]     r_den;
    logic [X25_W-1:0]   r_x25;
    logic [PCT_W-1:0]   r_pct;
    logic [LEVEL_W-1:0] r_smin;
    logic [LEVEL_W-1:0] r_smax;
    logic               r_pub;
    logic               r_out_vld;
    logic [47:0]        r_out_data;
    logic               r_out_pub;

    logic               accept;
    logic               win_start;
    logic               mode_clear;
    logic               div_start;
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    t_win_res           win_res;
    t_div_res           div_res;

    logic [LEVEL_W-1:0] in_level;
    logic [15:0]        w_span;
    logic [15:0]        st_span;
    logic [X_W-1:0]     st_r3;
    logic [X_W-1:0]     st_d4;
    logic [15:0]        st_d;
    logic [15:0]        cus_span;
    logic [15:0]        cus_v;
    logic [PCT_W-1:0]   q_clip;

    assign in_level        = i_s_axis_tdata[15:0];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign win_start       = accept && (r_mode == MODE_REACTIVE);
    assign mode_clear      = i_cfg_wr_en && (i_cfg_index == CFG_MODE);
    assign div_start       = (r_state == S_DIVGO);
    assign div_num         = {1'b0, r_x25, 11'd0} + {17'd0, r_den};
    assign div_den         = {r_den, 1'b0};

    always_comb begin
        w_span   = win_res.hi - win_res.lo;
        st_span  = r_ever_max - r_ever_min;
        st_r3    = {2'b00, st_span} + {1'b0, st_span, 1'b0};
        st_d     = (r_v > r_ever_min) ? r_v - r_ever_min : 16'd0;
        st_d4    = {st_d, 2'b00};
        cus_span = r_forced_max - r_forced_min;
        if (r_v < r_forced_min) begin
            cus_v = r_forced_min;
        end else if (r_v > r_forced_max) begin
            cus_v = r_forced_max;
        end else begin
            cus_v = r_v;
        end
        q_clip = (div_res.quot > PCT_FULL) ? PCT_FULL : div_res.quot;
    end

    lan_window #(
        .DEPTH(WINDOW_DEPTH)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (mode_clear),
        .i_start     (win_start),
        .i_level     (in_level),
        .i_time      (i_s_axis_tdata[47:16]),
        .i_window_ms (r_window_ms),
        .o_res       (win_res)
    );

    lan_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_REACTIVE;
            r_window_ms  <= 16'd1000;
            r_forced_min <= 16'd0;
            r_forced_max <= 16'hFFFF;
            r_min_span   <= 16'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MODE:       r_mode       <= t_mode'(i_cfg_wdata[1:0]);
                CFG_WINDOW_MS:  r_window_ms  <= i_cfg_wdata;
                CFG_FORCED_MIN: r_forced_min <= i_cfg_wdata;
                CFG_FORCED_MAX: r_forced_max <= i_cfg_wdata;
                CFG_MIN_SPAN:   r_min_span   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ever_min <= LEVEL_TOP;
            r_ever_max <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_v   <= in_level;
                        r_pct <= '0;
                        r_smin <= '0;
                        r_smax <= '0;
                        r_pub  <= 1'b0;
                        unique case (r_mode)
                            MODE_REACTIVE: r_state <= S_WIN;
                            MODE_STABLE: begin
                                if (in_level > r_ever_max) begin
                                    r_ever_max <= in_level;
                                end
                                if (in_level < r_ever_min) begin
                                    r_ever_min <= in_level;
                                end
                                r_changed <= (in_level > r_ever_max) ||
                                             (in_level < r_ever_min);
                                r_state <= S_ST;
                            end
                            MODE_CUSTOM: r_state <= S_CUS;
                            MODE_UNUSED: r_state <= S_OUT;
                            default:     r_state <= S_OUT;
                        endcase
                    end
                end
                S_WIN: begin
                    if (win_res.done) begin
                        r_smin <= win_res.lo;
                        r_smax <= win_res.hi;
                        r_pub  <= 1'b1;
                        r_x    <= {2'b00, r_v - win_res.lo};
                        r_den  <= {2'b00, w_span};
                        r_state <= (w_span > r_min_span) ? S_MUL : S_OUT;
                    end
                end
                S_ST: begin
                    if (r_changed) begin
                        r_smin <= r_ever_min;
                        r_smax <= r_ever_max;
                        r_pub  <= 1'b1;
                    end
                    r_x   <= (st_d4 > st_r3) ? st_r3 : st_d4;
                    r_den <= st_r3;
                    if (r_ever_max >= r_ever_min && st_span > r_min_span) begin
                        r_state <= S_MUL;
                    end else begin
                        r_pct   <= (r_v > r_ever_min) ? PCT_FULL : '0;
                        r_state <= S_OUT;
                    end
                end
                S_CUS: begin
                    r_x   <= {2'b00, cus_v - r_forced_min};
                    r_den <= {2'b00, cus_span};
                    if (r_forced_max > r_forced_min && cus_span > r_min_span) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_MUL: begin
                    // x * 25; the 2^10 factor of 25600 is folded into div_num's 11-bit shift and doubled divisor
                    r_x25   <= {1'b0, r_x, 4'd0} + {2'b00, r_x, 3'd0} + {5'd0, r_x};
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_res.done) begin
                        r_pct   <= q_clip;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_vld || i_m_axis_tready) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= {1'b0, r_smax, r_smin, r_pct};
                        r_out_pub  <= r_pub;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid   = r_out_vld;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_pub;

endmodule
